// ===== design/bamt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bamt_pkg
// Shared types, constants and the address fold for the breakpoint table.
// ----------------------------------------------------------------------------
package bamt_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int SLOT_W         = 4;
  localparam int ADDR_W         = 32;

  localparam logic [ADDR_W-1:0] FOLD_KEEP_BASE = 32'hFFFF8000;
  localparam logic [ADDR_W-1:0] BOOT_ROM_LO    = 32'hBFC00000;
  localparam logic [ADDR_W-1:0] BOOT_ROM_HI    = 32'hBFFFFFFF;
  localparam logic [ADDR_W-1:0] BOOT_ROM_MASK  = 32'h1FFFFFFF;
  localparam logic [ADDR_W-1:0] SEG_MASK       = 32'h7FFFFFFF;
  localparam logic [3:0]        MIRROR_TOP_A   = 4'h2;
  localparam logic [3:0]        MIRROR_TOP_B   = 4'h3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } bamt_state_t;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot_index;
    logic              slot_valid;
    logic [ADDR_W-1:0] slot_address;
    logic              slot_enabled;
    logic              slot_temporary;
    logic              slot_has_condition;
    logic [ADDR_W-1:0] query_address;
  } bamt_in_t;

  typedef struct packed {
    logic              break_hit;
    logic              present;
    logic              present_enabled;
    logic [SLOT_W-1:0] match_slot;
    logic              condition_present;
    logic [SLOT_W-1:0] condition_slot;
    logic [ADDR_W-1:0] normalized_address;
  } bamt_out_t;

  // one table entry as kept in the slot ram, address already folded
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              enabled;
    logic              temporary;
    logic              has_cond;
  } bamt_entry_t;

  typedef struct packed {
    logic load_query;
    logic write_slot;
    logic rd_en;
    logic finish_write;
    logic finish_query;
  } bamt_cmd_t;

  function automatic logic [ADDR_W-1:0] fold_address(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] v;
    v = a;
    if (a < FOLD_KEEP_BASE) begin
      if (v >= BOOT_ROM_LO && v <= BOOT_ROM_HI) begin
        v = v & BOOT_ROM_MASK;
      end
      v = v & SEG_MASK;
      if (v[31:28] == MIRROR_TOP_A || v[31:28] == MIRROR_TOP_B) begin
        v[31:28] = 4'h0;
      end
    end
    return v;
  endfunction

endpackage

// ===== design/bamt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bamt_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module bamt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/bamt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bamt_ctrl
// Sequencer: takes words, steps the slot scan and tells the datapath when to
// write, load, read and report.
// ----------------------------------------------------------------------------
module bamt_ctrl #(
  parameter int SLOT_COUNT = bamt_pkg::SLOT_COUNT_DEF,
  localparam int IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                action,
  output logic                busy,
  output bamt_pkg::bamt_cmd_t cmd,
  output logic [IDX_W-1:0]    rd_idx
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  bamt_pkg::bamt_state_t state, state_next;
  logic [IDX_W-1:0]      cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bamt_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    rd_idx     = cnt;
    busy       = (state != bamt_pkg::ST_IDLE);
    case (state)
      bamt_pkg::ST_IDLE: begin
        rd_idx = '0;
        if (start) begin
          if (action == bamt_pkg::ACT_QUERY) begin
            // slot 0 is read in the accept cycle
            cmd.load_query = 1'b1;
            cmd.rd_en      = 1'b1;
            cnt_next       = IDX_W'(1);
            state_next     = (SLOT_COUNT == 1) ? bamt_pkg::ST_DRAIN : bamt_pkg::ST_SCAN;
          end else begin
            cmd.write_slot   = 1'b1;
            cmd.finish_write = 1'b1;
          end
        end
      end
      bamt_pkg::ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_next  = cnt + IDX_W'(1);
        if (cnt == LAST_IDX) begin
          state_next = bamt_pkg::ST_DRAIN;
        end
      end
      bamt_pkg::ST_DRAIN: begin
        state_next = bamt_pkg::ST_DONE;
      end
      bamt_pkg::ST_DONE: begin
        cmd.finish_query = 1'b1;
        state_next       = bamt_pkg::ST_IDLE;
      end
      default: begin
        state_next = bamt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/bamt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bamt_datapath
// Slot table, folded query register, one compare per cycle against the slot
// read back, match accumulators and the result register.
// ----------------------------------------------------------------------------
module bamt_datapath #(
  parameter int SLOT_COUNT = bamt_pkg::SLOT_COUNT_DEF,
  localparam int IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  bamt_pkg::bamt_cmd_t cmd,
  input  logic [IDX_W-1:0]    rd_idx,
  input  bamt_pkg::bamt_in_t  item,
  output logic                done,
  output bamt_pkg::bamt_out_t result
);

  localparam int ENTRY_W = $bits(bamt_pkg::bamt_entry_t);

  logic [SLOT_COUNT-1:0]           valid_bits;
  logic [bamt_pkg::ADDR_W-1:0]     q;
  logic [IDX_W-1:0]                wr_addr;
  logic                            wr_en;
  bamt_pkg::bamt_entry_t           wr_entry;
  logic [ENTRY_W-1:0]              rdata;
  bamt_pkg::bamt_entry_t           rd_entry;

  logic                            cmp_en;
  logic                            cmp_valid;
  logic [IDX_W-1:0]                cmp_idx;
  logic                            match;

  logic                            first_found;
  logic                            first_en;
  logic [IDX_W-1:0]                first_idx;
  logic                            temp_found;
  logic                            temp_en;
  logic                            plain_found;
  logic                            plain_cond;
  logic [IDX_W-1:0]                plain_idx;
  logic                            cond_apply;

  assign wr_addr = IDX_W'(item.slot_index);
  assign wr_en   = cmd.write_slot && (32'(item.slot_index) < 32'(SLOT_COUNT));

  // slot addresses are kept folded, so the scan compares directly
  always_comb begin
    wr_entry.addr      = bamt_pkg::fold_address(item.slot_address);
    wr_entry.enabled   = item.slot_enabled;
    wr_entry.temporary = item.slot_temporary;
    wr_entry.has_cond  = item.slot_has_condition;
  end

  bamt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_entry),
    .re   (cmd.rd_en),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  assign rd_entry = bamt_pkg::bamt_entry_t'(rdata);
  assign match    = cmp_en && cmp_valid && (rd_entry.addr == q);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_addr] <= item.slot_valid;
    end
  end

  // valid bit and index are registered alongside the ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= cmd.rd_en;
    end
    cmp_valid <= valid_bits[rd_idx];
    cmp_idx   <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q <= bamt_pkg::fold_address(item.query_address);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_query) begin
      first_found <= 1'b0;
      temp_found  <= 1'b0;
      plain_found <= 1'b0;
    end else if (match) begin
      if (!first_found) begin
        first_found <= 1'b1;
      end
      if (rd_entry.temporary && !temp_found) begin
        temp_found <= 1'b1;
      end
      if (!rd_entry.temporary && !plain_found) begin
        plain_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (match) begin
      if (!first_found) begin
        first_en  <= rd_entry.enabled;
        first_idx <= cmp_idx;
      end
      if (rd_entry.temporary && !temp_found) begin
        temp_en <= rd_entry.enabled;
      end
      if (!rd_entry.temporary && !plain_found) begin
        plain_cond <= rd_entry.has_cond;
        plain_idx  <= cmp_idx;
      end
    end
  end

  // a temporary match suppresses the conditional report
  assign cond_apply = !temp_found && plain_found && plain_cond;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish_write || cmd.finish_query;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_write) begin
      result <= '0;
    end else if (cmd.finish_query) begin
      result.break_hit          <= (first_found && first_en) || (temp_found && temp_en);
      result.present            <= first_found;
      result.present_enabled    <= first_found && first_en;
      result.match_slot         <= first_found ? bamt_pkg::SLOT_W'(first_idx) : '0;
      result.condition_present  <= cond_apply;
      result.condition_slot     <= cond_apply ? bamt_pkg::SLOT_W'(plain_idx) : '0;
      result.normalized_address <= q;
    end
  end

endmodule

// ===== design/breakpoint_address_match_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_address_match_table_top
// Breakpoint slot table with folded address matching, first match in slot
// order, temporary fallback and conditional slot report.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   input     start & !busy        item   (bamt_in_t)
//   result    done, one cycle      result (bamt_out_t)
//
// a write word is taken while idle, its all-zero result strobes in the next cycle
// a query reads one slot per cycle from the slot ram, then compares each
// slot in the cycle after its read, and the next word can be taken in the
// cycle in which the result strobes
// reset clears all valid bits at once, so no clearing pass is needed
// the receiver cannot stall: done marks each result for one cycle only
//
module breakpoint_address_match_table_top #(
  parameter int SLOT_COUNT = bamt_pkg::SLOT_COUNT_DEF,
  localparam int IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bamt_pkg::bamt_in_t  item,
  output logic                done,
  output bamt_pkg::bamt_out_t result
);

  bamt_pkg::bamt_cmd_t cmd;
  logic [IDX_W-1:0]    rd_idx;

  bamt_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(item.action),
    .busy  (busy),
    .cmd   (cmd),
    .rd_idx(rd_idx)
  );

  bamt_datapath #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .rd_idx(rd_idx),
    .item  (item),
    .done  (done),
    .result(result)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the breakpoint address match table. Slot writes and
// address lookups are sent in bursts with random gaps. Each accepted word is
// run through a local table model that folds addresses and scans the slots in
// index order. Every strobed result is checked field by field against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int SLOTS      = bamt_pkg::SLOT_COUNT_DEF;
  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_WORDS = 1100;
  localparam int POOL_SIZE  = 6;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  bamt_pkg::bamt_in_t  item = '0;
  logic                done;
  bamt_pkg::bamt_out_t result;

  breakpoint_address_match_table_top #(.SLOT_COUNT(SLOTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // local copy of the slot table
  logic [bamt_pkg::ADDR_W-1:0] tbl_addr  [SLOTS];
  logic                        tbl_valid [SLOTS];
  logic                        tbl_en    [SLOTS];
  logic                        tbl_temp  [SLOTS];
  logic                        tbl_cond  [SLOTS];

  bamt_pkg::bamt_in_t          word_q[$];
  bamt_pkg::bamt_out_t         result_due_q[$];
  logic [bamt_pkg::ADDR_W-1:0] addr_pool[POOL_SIZE];

  logic took = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   words_taken = 0;
  int   total_words = 0;
  int   idle_cycles = 0;
  int   error_count = 0;
  int   n_writes = 0;
  int   n_queries = 0;
  int   n_present = 0;
  int   n_hits = 0;
  int   n_cond = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_addr[i]  = '0;
      tbl_valid[i] = 1'b0;
      tbl_en[i]    = 1'b0;
      tbl_temp[i]  = 1'b0;
      tbl_cond[i]  = 1'b0;
    end
  end

  function automatic logic [bamt_pkg::ADDR_W-1:0] canon_addr(
      input logic [bamt_pkg::ADDR_W-1:0] a);
    logic [bamt_pkg::ADDR_W-1:0] v;
    v = a;
    if (v >= bamt_pkg::FOLD_KEEP_BASE) begin
      return v;
    end
    // boot rom window: top ten bits all match 0xBFC
    if (v[31:22] == 10'h2FF) begin
      v[31:29] = 3'b000;
    end
    v[31] = 1'b0;
    // kseg mirrors with top nibble 2 or 3
    if (v[31:29] == 3'b001) begin
      v[31:28] = 4'h0;
    end
    return v;
  endfunction

  task automatic table_step(input bamt_pkg::bamt_in_t w, output bamt_pkg::bamt_out_t r);
    logic [bamt_pkg::ADDR_W-1:0] q;
    int first;
    int tmp_hit;
    int plain;
    r = '0;
    if (w.action == bamt_pkg::ACT_WRITE) begin
      tbl_valid[w.slot_index] = w.slot_valid;
      tbl_addr[w.slot_index]  = w.slot_address;
      tbl_en[w.slot_index]    = w.slot_enabled;
      tbl_temp[w.slot_index]  = w.slot_temporary;
      tbl_cond[w.slot_index]  = w.slot_has_condition;
      n_writes++;
    end else begin
      q = canon_addr(w.query_address);
      first = -1;
      tmp_hit = -1;
      plain = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_valid[i] && canon_addr(tbl_addr[i]) == q) begin
          if (first < 0) first = i;
          if (tbl_temp[i] && tmp_hit < 0) tmp_hit = i;
          if (!tbl_temp[i] && plain < 0) plain = i;
        end
      end
      r.break_hit = (first >= 0 && tbl_en[first]) || (tmp_hit >= 0 && tbl_en[tmp_hit]);
      if (first >= 0) begin
        r.present         = 1'b1;
        r.present_enabled = tbl_en[first];
        r.match_slot      = first[bamt_pkg::SLOT_W-1:0];
      end
      // a temporary match hides any conditional slot
      if (tmp_hit < 0 && plain >= 0 && tbl_cond[plain]) begin
        r.condition_present = 1'b1;
        r.condition_slot    = plain[bamt_pkg::SLOT_W-1:0];
      end
      r.normalized_address = q;
      n_queries++;
      if (r.present) n_present++;
      if (r.break_hit) n_hits++;
      if (r.condition_present) n_cond++;
    end
  endtask

  task automatic log_fault(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("tb: mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic bamt_pkg::bamt_in_t mk_write(input logic [3:0] idx, input logic v,
                                                  input logic [bamt_pkg::ADDR_W-1:0] a,
                                                  input logic en, input logic tmp,
                                                  input logic cnd);
    bamt_pkg::bamt_in_t w;
    logic [95:0]        raw;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(bamt_pkg::bamt_in_t)-1:0];
    w.action             = bamt_pkg::ACT_WRITE;
    w.slot_index         = idx;
    w.slot_valid         = v;
    w.slot_address       = a;
    w.slot_enabled       = en;
    w.slot_temporary     = tmp;
    w.slot_has_condition = cnd;
    return w;
  endfunction

  function automatic bamt_pkg::bamt_in_t mk_query(input logic [bamt_pkg::ADDR_W-1:0] a);
    bamt_pkg::bamt_in_t w;
    logic [95:0]        raw;
    raw = {$urandom, $urandom, $urandom};
    w = raw[$bits(bamt_pkg::bamt_in_t)-1:0];
    w.action        = bamt_pkg::ACT_QUERY;
    w.query_address = a;
    return w;
  endfunction

  function automatic logic [bamt_pkg::ADDR_W-1:0] pick_canon();
    case ($urandom_range(0, 2))
      0: return $urandom & 32'h00FF_FFFF;
      1: return 32'h1FC0_0000 | ($urandom & 32'h003F_FFFF);
      default: return 32'hFFFF_8000 | ($urandom & 32'h0000_7FFF);
    endcase
  endfunction

  // raw address that folds back onto canonical value c
  function automatic logic [bamt_pkg::ADDR_W-1:0] alias_of(
      input logic [bamt_pkg::ADDR_W-1:0] c);
    logic [3:0] tops [6];
    tops = '{4'h0, 4'h2, 4'h3, 4'h8, 4'hA, 4'hB};
    if (c >= bamt_pkg::FOLD_KEEP_BASE) begin
      return c;
    end
    if (c[31:28] == 4'h1) begin
      case ($urandom_range(0, 2))
        0: return c;
        1: return c | 32'h8000_0000;
        default: return c | 32'hA000_0000;
      endcase
    end
    return {tops[$urandom_range(0, 5)], c[27:0]};
  endfunction

  function automatic logic [bamt_pkg::ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 99) < 15) begin
      return $urandom;
    end
    return alias_of(addr_pool[$urandom_range(0, POOL_SIZE - 1)]);
  endfunction

  // driver: new word presented at the falling edge once the last one is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (word_q.size() != 0) begin
        item  <= word_q.pop_front();
        start <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 6);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the strobed result first, then predict the word taken
  always @(posedge clk) begin
    bamt_pkg::bamt_out_t got;
    bamt_pkg::bamt_out_t want;
    bamt_pkg::bamt_out_t nxt;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= start && !busy;
      if (done) begin
        got = result;
        if (result_due_q.size() == 0) begin
          log_fault($sformatf("result with nothing outstanding: %h", got));
        end else begin
          want = result_due_q.pop_front();
          if (got.break_hit !== want.break_hit)
            log_fault($sformatf("break_hit exp %0b got %0b", want.break_hit, got.break_hit));
          if (got.present !== want.present)
            log_fault($sformatf("present exp %0b got %0b", want.present, got.present));
          if (got.present_enabled !== want.present_enabled)
            log_fault($sformatf("present_enabled exp %0b got %0b",
                                want.present_enabled, got.present_enabled));
          if (got.match_slot !== want.match_slot)
            log_fault($sformatf("match_slot exp %0d got %0d", want.match_slot, got.match_slot));
          if (got.condition_present !== want.condition_present)
            log_fault($sformatf("condition_present exp %0b got %0b",
                                want.condition_present, got.condition_present));
          if (got.condition_slot !== want.condition_slot)
            log_fault($sformatf("condition_slot exp %0d got %0d",
                                want.condition_slot, got.condition_slot));
          if (got.normalized_address !== want.normalized_address)
            log_fault($sformatf("normalized_address exp %h got %h",
                                want.normalized_address, got.normalized_address));
        end
      end
      if (start && !busy) begin
        table_step(item, nxt);
        result_due_q.push_back(nxt);
        words_taken <= words_taken + 1;
      end
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: no progress for %0d cycles", IDLE_LIMIT);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      addr_pool[i] = pick_canon();
    end

    // empty table, then folding, fallback and flag corners
    word_q.push_back(mk_query(32'h0000_0000));
    word_q.push_back(mk_query(32'hFFFF_FFFF));
    word_q.push_back(mk_write(4'd0, 1'b1, 32'hBFC0_0100, 1'b1, 1'b0, 1'b0));
    word_q.push_back(mk_query(32'h9FC0_0100));
    word_q.push_back(mk_query(32'hBFC0_0100));
    word_q.push_back(mk_write(4'd1, 1'b1, 32'h2000_1000, 1'b1, 1'b1, 1'b0));
    word_q.push_back(mk_query(32'h8000_1000));
    word_q.push_back(mk_query(32'hB000_1000));
    word_q.push_back(mk_write(4'd2, 1'b1, 32'hFFFF_8000, 1'b1, 1'b0, 1'b1));
    word_q.push_back(mk_query(32'hFFFF_8000));
    word_q.push_back(mk_query(32'h7FFF_8000));
    word_q.push_back(mk_query(32'hFFFF_7FFF));
    // condition on a disabled slot
    word_q.push_back(mk_write(4'd3, 1'b1, 32'h0040_0000, 1'b0, 1'b0, 1'b1));
    word_q.push_back(mk_query(32'h0040_0000));
    // later enabled temporary slot on the same folded address
    word_q.push_back(mk_write(4'd4, 1'b1, 32'h3040_0000, 1'b1, 1'b1, 1'b0));
    word_q.push_back(mk_query(32'hA040_0000));
    // remove it again
    word_q.push_back(mk_write(4'd4, 1'b0, 32'h3040_0000, 1'b1, 1'b1, 1'b0));
    word_q.push_back(mk_query(32'h0040_0000));
    word_q.push_back(mk_write(4'd15, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    word_q.push_back(mk_query(32'hFFFF_FFFF));
    // disabled temporary slot hides the condition but does not break
    word_q.push_back(mk_write(4'd5, 1'b1, 32'h0000_0000, 1'b0, 1'b1, 1'b1));
    word_q.push_back(mk_query(32'h8000_0000));
    word_q.push_back(mk_write(4'd6, 1'b1, 32'hBFFF_FFFF, 1'b1, 1'b0, 1'b1));
    word_q.push_back(mk_query(32'h9FFF_FFFF));
    word_q.push_back(mk_query(32'hBFBF_FFFF));

    for (int n = 0; n < RAND_WORDS; n++) begin
      if ($urandom_range(0, 49) == 0) begin
        addr_pool[$urandom_range(0, POOL_SIZE - 1)] = pick_canon();
      end
      if ($urandom_range(0, 99) < 35) begin
        word_q.push_back(mk_write(4'($urandom_range(0, SLOTS - 1)),
                                  ($urandom_range(0, 99) < 85), pick_addr(),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
      end else begin
        word_q.push_back(mk_query(pick_addr()));
      end
    end
    total_words = word_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (words_taken < total_words) @(posedge clk);
    while (result_due_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("tb: %0d words sent, %0d slot writes and %0d lookups", total_words,
             n_writes, n_queries);
    $display("tb: lookups with a match %0d, breaks %0d, condition reports %0d",
             n_present, n_hits, n_cond);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches", error_count);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== breakpoint_address_match_table_top.f =====
design/bamt_pkg.sv
design/bamt_ram.sv
design/bamt_ctrl.sv
design/bamt_datapath.sv
design/breakpoint_address_match_table_top.sv
bench/tb.sv
